FILE: rtl/lbp_pkg.sv
package lbp_pkg;

    // Frame geometry limits and field widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int NUM_BINS   = 256;

    localparam int DIM_W   = 11;
    localparam int PIX_W   = 8;
    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int COUNT_W = 20;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (SIZE_W > DIM_W) ? SIZE_W : DIM_W;

    // Configuration register map.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0]     HEIGHT_RESET     = DIM_W'(480);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic KIND_CODE  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // One histogram operation handed from the front to the back.
    typedef struct packed {
        t_op              op;
        logic [BIN_W-1:0] addr;
        logic             last;
    } t_hist_op;

    // One result beat.
    typedef struct packed {
        logic               kind;
        logic [PIX_W-1:0]   code;
        logic [COUNT_W-1:0] count;
        logic               done;
    } t_result;

endpackage

FILE: rtl/lbp_front.sv
module lbp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbp_pkg::DIM_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [lbp_pkg::PIX_W-1:0]       i_pixel,
    input  logic [lbp_pkg::BIN_W-1:0]       i_bin_index,
    output logic                            o_push,
    output lbp_pkg::t_hist_op               o_op,
    input  logic                            i_full
);
    import lbp_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [CMP_W-1:0] ve;
        logic [CMP_W-1:0] he;
        ve = CMP_W'(v);
        he = CMP_W'(hi);
        if (ve < CMP_W'(3)) begin
            return SIZE_W'(3);
        end else if (ve > he) begin
            return hi;
        end
        return SIZE_W'(ve);
    endfunction

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [SIZE_W-1:0] r_row, n_row;
    logic              r_done, n_done;
    logic [PIX_W-1:0]  r_win [6];
    logic [PIX_W-1:0]  r_top;
    logic [PIX_W-1:0]  r_mid;
    logic [PIX_W-1:0]  mem_upper  [MAX_WIDTH];
    logic [PIX_W-1:0]  mem_middle [MAX_WIDTH];

    logic              accept;
    logic              px_go;
    logic              take;
    logic              start;
    logic              emit;
    logic              col_end;
    logic              last;
    logic [SIZE_W-1:0] col_ext;
    logic [PIX_W-1:0]  ctr;
    logic [PIX_W-1:0]  code;
    logic [COL_W-1:0]  rd_addr;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign col_ext = SIZE_W'(r_col);
    assign col_end = (col_ext + SIZE_W'(1)) >= r_width;
    assign last    = ((r_row + SIZE_W'(1)) >= r_height) && col_end;
    assign emit    = (r_row >= SIZE_W'(2)) && (col_ext >= SIZE_W'(2));
    assign ctr     = r_win[4];
    assign code    = {r_win[0] > ctr, r_win[3] > ctr, r_top > ctr, r_mid > ctr,
                      i_pixel > ctr, r_win[5] > ctr, r_win[2] > ctr, r_win[1] > ctr};

    always_comb begin
        px_go  = 1'b0;
        start  = 1'b0;
        o_push = 1'b0;
        o_op   = '{op: OP_COUNT, addr: code, last: last};
        if (accept) begin
            unique case (t_cmd'(i_cmd))
                CMD_PIXEL: px_go = !r_done;
                CMD_READ: begin
                    o_push = 1'b1;
                    o_op   = '{op: OP_READ, addr: i_bin_index, last: 1'b0};
                end
                CMD_START: begin
                    start  = 1'b1;
                    o_push = 1'b1;
                    o_op   = '{op: OP_CLEAR, addr: '0, last: 1'b0};
                end
                default: ;
            endcase
        end
        take = px_go && (r_row < r_height);
        if (take && emit) begin
            o_push = 1'b1;
        end
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_done = r_done;
        if (start) begin
            n_col  = '0;
            n_row  = '0;
            n_done = 1'b0;
        end else if (px_go && !take) begin
            n_done = 1'b1;
        end else if (take) begin
            if (col_end) begin
                n_col = '0;
                n_row = r_row + SIZE_W'(1);
                if ((r_row + SIZE_W'(1)) >= r_height) begin
                    n_done = 1'b1;
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_dim(WIDTH_RESET, MAX_W_S);
            r_height <= clamp_dim(HEIGHT_RESET, MAX_H_S);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= clamp_dim(i_cfg_data, MAX_W_S);
            end else if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_height <= clamp_dim(i_cfg_data, MAX_H_S);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_done <= n_done;
            if (start) begin
                for (int k = 0; k < 6; k++) begin
                    r_win[k] <= '0;
                end
            end else if (take) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= r_top;
                r_win[4] <= r_mid;
                r_win[5] <= i_pixel;
            end
        end
    end

    // The line stores are read ahead at the column of the next pixel, so the
    // registered data always belongs to the current column.
    assign rd_addr = i_rst_n ? n_col : '0;

    always_ff @(posedge i_clk) begin
        if (take) begin
            mem_upper[r_col]  <= r_mid;
            mem_middle[r_col] <= i_pixel;
        end
        r_top <= mem_upper[rd_addr];
        r_mid <= mem_middle[rd_addr];
    end

endmodule

FILE: rtl/lbp_queue.sv
module lbp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lbp_pkg::t_hist_op i_op,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output lbp_pkg::t_hist_op o_op
);
    import lbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_hist_op         r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_slot[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= PTR_W'((int'(r_wr) + 1) % QUEUE_DEPTH);
            end
            if (do_pop) begin
                r_rd <= PTR_W'((int'(r_rd) + 1) % QUEUE_DEPTH);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

endmodule

FILE: rtl/lbp_back.sv
module lbp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  lbp_pkg::t_hist_op i_q_op,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output lbp_pkg::t_result  o_result
);
    import lbp_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    // Histogram storage; a bin whose valid bit is clear reads as zero.
    logic [COUNT_W-1:0]  mem_hist [NUM_BINS];
    logic [NUM_BINS-1:0] r_bin_vld;

    logic [COUNT_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_ex_valid;
    t_hist_op           r_ex;
    logic               r_lw_valid;
    logic [BIN_W-1:0]   r_lw_addr;
    logic [COUNT_W-1:0] r_lw_data;

    t_result            r_obuf [OUT_DEPTH];
    logic [PTR_W-1:0]   r_owr;
    logic [PTR_W-1:0]   r_ord;
    logic [CNT_W-1:0]   r_ocnt;

    logic [CNT_W:0]     pending;
    logic               issue;
    logic               is_clear;
    logic               ex_write;
    logic               out_pop;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] inc;
    t_result            ex_res;

    // Issue only while the output buffer has room for everything in flight.
    assign pending  = (CNT_W + 1)'(r_ocnt) + (CNT_W + 1)'(r_ex_valid);
    assign issue    = i_q_valid && (pending <= (CNT_W + 1)'(OUT_DEPTH - 2));
    assign o_pop    = issue;
    assign is_clear = i_q_op.op == OP_CLEAR;

    always_comb begin
        if (r_lw_valid && (r_lw_addr == r_ex.addr)) begin
            cur = r_lw_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
        inc      = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
        ex_write = r_ex_valid && (r_ex.op == OP_COUNT);
        if (r_ex.op == OP_COUNT) begin
            ex_res = '{kind: KIND_CODE, code: r_ex.addr, count: '0, done: r_ex.last};
        end else begin
            ex_res = '{kind: KIND_COUNT, code: '0, count: cur, done: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_lw_valid <= 1'b0;
            r_bin_vld  <= '0;
        end else begin
            r_ex_valid <= issue && !is_clear;
            // A clear follows the operation in execution, so it wins.
            if (issue && is_clear) begin
                r_bin_vld  <= '0;
                r_lw_valid <= 1'b0;
            end else begin
                r_lw_valid <= ex_write;
                if (ex_write) begin
                    r_bin_vld[r_ex.addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_write) begin
            mem_hist[r_ex.addr] <= inc;
        end
        r_rd_data <= mem_hist[i_q_op.addr];
        r_rd_vld  <= r_bin_vld[i_q_op.addr];
        r_lw_addr <= r_ex.addr;
        r_lw_data <= inc;
        if (issue) begin
            r_ex <= i_q_op;
        end
    end

    assign o_valid  = r_ocnt != '0;
    assign o_result = r_obuf[r_ord];
    assign out_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_ex_valid) begin
                r_owr <= PTR_W'((int'(r_owr) + 1) % OUT_DEPTH);
            end
            if (out_pop) begin
                r_ord <= PTR_W'((int'(r_ord) + 1) % OUT_DEPTH);
            end
            r_ocnt <= r_ocnt + CNT_W'(r_ex_valid) - CNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ex_valid) begin
            r_obuf[r_owr] <= ex_res;
        end
    end

endmodule

FILE: rtl/lbp_code_histogram.sv
// Local binary pattern coder with a 256-bin code histogram. Each input beat
// carries a command: a grey pixel in raster order, a request to read one
// histogram bin, or a start command that begins a new frame and clears the
// histogram via bin valid bits (no clearing pass, also not after reset). For
// every interior pixel of the frame the block returns one beat with the 8-bit
// code of the 3x3 window centred one row up and one column left of the pixel
// just taken; frame_done marks the last code of the frame. Pixels in the first
// two rows and columns, pixels after the frame end and unknown commands return
// nothing. A bin read returns one beat with the bin's 20-bit saturating count,
// which includes every code sent before the read. The block takes one beat per
// clock and returns one result per clock while the output is not stalled; a
// result passes the operation queue, the execute register and the output
// buffer before it is presented. The rate is set by the line stores, which
// are read ahead one column and written once per pixel, and by the histogram
// memory, which does one read-modify-write per clock with forwarding of the
// previous update. Image width and height are to be written only while the
// block is idle, which is not enforced; they are clamped to the range 3 to 1024.
module lbp_code_histogram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lbp_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [lbp_pkg::PIX_W-1:0]     i_pixel,
    input  logic [lbp_pkg::BIN_W-1:0]     i_bin_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic [lbp_pkg::PIX_W-1:0]     o_lbp_code,
    output logic [lbp_pkg::COUNT_W-1:0]   o_bin_count,
    output logic                          o_frame_done
);
    import lbp_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_hist_op push_op;
    t_hist_op head_op;
    t_result  result;

    // The front end owns the frame position, the window and the line stores.
    // It turns every beat into at most one histogram operation.
    lbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .i_bin_index (i_bin_index),
        .o_push      (q_push),
        .o_op        (push_op),
        .i_full      (q_full)
    );

    // The queue keeps the operations in order and lets the front keep taking
    // pixels while the output side is stalled, until the queue is full.
    lbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    // The back end updates, reads or clears the histogram and buffers the results.
    lbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (head_op),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_kind       = result.kind;
    assign o_lbp_code   = result.code;
    assign o_bin_count  = result.count;
    assign o_frame_done = result.done;

`ifndef SYNTHESIS
    // The front never pushes into a full queue.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("operation pushed into a full queue");

    // A count beat carries no code and no frame end.
    a_count_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_COUNT)) |-> ((o_lbp_code == '0) && !o_frame_done))
        else $error("count beat carries code bits");

    // A code beat carries a zero count.
    a_code_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_CODE)) |-> (o_bin_count == '0))
        else $error("code beat carries a count");
`endif

endmodule

FILE: tb/lbp_code_histogram_checker.sv
module lbp_code_histogram_checker
    import lbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic [BIN_W-1:0]     i_bin_index,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_kind,
    input  logic [PIX_W-1:0]     i_lbp_code,
    input  logic [COUNT_W-1:0]   i_bin_count,
    input  logic                 i_frame_done,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_codes_checked,
    output int                   o_reads_checked,
    output int                   o_frames_closed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // Shadow copy of the configuration and of the block's pixel pipeline.
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [PIX_W-1:0]   upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
    // Window columns, each held as top, middle, bottom.
    logic [PIX_W-1:0]   old_col [3];
    logic [PIX_W-1:0]   prev_col [3];
    logic [COUNT_W-1:0] code_hist [NUM_BINS];
    int unsigned        row_pos;
    int unsigned        col_pos;
    bit                 frame_closed;

    t_result            expected_beats [$];
    int                 mismatches = 0;
    int                 codes_checked = 0;
    int                 reads_checked = 0;
    int                 frames_closed = 0;

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        foreach (code_hist[i]) code_hist[i] = '0;
        foreach (old_col[i]) begin
            old_col[i]  = '0;
            prev_col[i] = '0;
        end
        row_pos      = 0;
        col_pos      = 0;
        frame_closed = 1'b0;
    endfunction

    // Works out what one accepted input beat returns and advances the shadow state.
    function automatic void predict_beat(input logic [1:0] cmd, input logic [PIX_W-1:0] px,
                                         input logic [BIN_W-1:0] bin);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] ctr;
        logic [PIX_W-1:0] code;
        bit               emit;
        bit               last;
        t_result          res;
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        r   = row_pos;
        c   = col_pos;
        res = '0;
        if (cmd == CMD_READ) begin
            res.kind  = KIND_COUNT;
            res.count = code_hist[bin];
            expected_beats.push_back(res);
            return;
        end
        if (cmd == CMD_START) begin
            restart_frame();
            return;
        end
        if (cmd != CMD_PIXEL || frame_closed) return;
        // A height lowered below the current row closes the frame on this pixel.
        if (r >= h) begin
            frame_closed = 1'b1;
            return;
        end
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;

        top  = upper_row[c];
        mid  = middle_row[c];
        emit = (r >= 2) && (c >= 2);
        last = (r + 1 >= h) && (c + 1 >= w);
        if (emit) begin
            ctr  = prev_col[1];
            code = {old_col[0] > ctr, prev_col[0] > ctr, top > ctr, mid > ctr, px > ctr,
                    prev_col[2] > ctr, old_col[2] > ctr, old_col[1] > ctr};
            if (code_hist[code] != COUNT_MAX) code_hist[code] = code_hist[code] + 1'b1;
            res.kind = KIND_CODE;
            res.code = code;
            res.done = last;
            expected_beats.push_back(res);
        end

        old_col       = prev_col;
        prev_col      = '{top, mid, px};
        upper_row[c]  = mid;
        middle_row[c] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) frame_closed = 1'b1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic void report_mismatch(input string what, input t_result want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s: expected kind %0d code %02h count %0d done %0d",
                     $realtime, what, want.kind, want.code, want.count, want.done);
            $display("    got kind %0d code %02h count %0d done %0d",
                     i_kind, i_lbp_code, i_bin_count, i_frame_done);
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (expected_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected", '0);
            return;
        end
        want = expected_beats.pop_front();
        if (i_kind !== want.kind || i_lbp_code !== want.code ||
            i_bin_count !== want.count || i_frame_done !== want.done) begin
            report_mismatch("result beat differs", want);
        end
        if (want.kind == KIND_CODE) codes_checked++;
        else reads_checked++;
        if (want.done) frames_closed++;
    endfunction

    // Results are checked before the same edge's input beat is predicted; the
    // block cannot return a result in the cycle its beat is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            restart_frame();
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: width_reg = i_cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_beat(i_cmd, i_pixel, i_bin_index);
        end
        o_pending       <= expected_beats.size();
        o_mismatches    <= mismatches;
        o_codes_checked <= codes_checked;
        o_reads_checked <= reads_checked;
        o_frames_closed <= frames_closed;
    end

endmodule

FILE: tb/lbp_code_histogram_tb.sv
module lbp_code_histogram_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    // Command code 3 has no meaning; the block must drop such beats silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Upper bound of the random gap that each side draws before its next beat.
    localparam int MAX_GAP = 5;
    // Extra wait once every expected result has arrived; it leaves ample margin
    // for a pixel beat that produced nothing to clear the pipeline.
    localparam int SETTLE_CYCLES = 8;
    // The longest quiet stretch of a correct run is a drain plus the settle
    // wait, two register writes and one sender gap.
    localparam int STALL_LIMIT = 400;
    localparam int RANDOM_BEATS = 700;
    // Columns taken under the clamped full width before the row is cut short.
    localparam int CLAMP_COLS = 60;

    // A 3x3 frame in raster order. Its centre of 100 has an equal neighbor on
    // the left, neighbors at both pixel extremes and neighbors just above and
    // just below it, so it checks the strictly-greater rule on every bit.
    localparam logic [0:8][PIX_W-1:0] PROBE_FRAME = {
        8'd255, 8'd0,   8'd255,
        8'd100, 8'd100, 8'd101,
        8'd0,   8'd255, 8'd99
    };
    localparam logic [BIN_W-1:0] PROBE_CODE = 8'hB4;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 src_valid = 1'b0;
    logic                 dut_ready;
    logic [1:0]           src_cmd = CMD_PIXEL;
    logic [PIX_W-1:0]     src_pixel = '0;
    logic [BIN_W-1:0]     src_bin = '0;
    logic                 res_valid;
    logic                 sink_ready = 1'b0;
    logic                 res_kind;
    logic [PIX_W-1:0]     res_code;
    logic [COUNT_W-1:0]   res_count;
    logic                 res_done;

    int                   mismatches;
    int                   pending;
    int                   codes_checked;
    int                   reads_checked;
    int                   frames_closed;

    // When set, both sides run back to back without idle cycles.
    bit                   no_idle = 1'b0;
    int                   beats_sent = 0;
    int                   quiet_cycles = 0;

    always #1 clk = ~clk;

    lbp_code_histogram i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (src_valid),
        .o_ready      (dut_ready),
        .i_cmd        (src_cmd),
        .i_pixel      (src_pixel),
        .i_bin_index  (src_bin),
        .o_valid      (res_valid),
        .i_ready      (sink_ready),
        .o_kind       (res_kind),
        .o_lbp_code   (res_code),
        .o_bin_count  (res_count),
        .o_frame_done (res_done)
    );

    lbp_code_histogram_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (src_valid),
        .i_in_ready      (dut_ready),
        .i_cmd           (src_cmd),
        .i_pixel         (src_pixel),
        .i_bin_index     (src_bin),
        .i_out_valid     (res_valid),
        .i_out_ready     (sink_ready),
        .i_kind          (res_kind),
        .i_lbp_code      (res_code),
        .i_bin_count     (res_count),
        .i_frame_done    (res_done),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_codes_checked (codes_checked),
        .o_reads_checked (reads_checked),
        .o_frames_closed (frames_closed)
    );

    function automatic int next_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Pixel textures: full range, a few grey levels so that equal neighbors
    // are common, only the two extremes, and a narrow band around mid-grey.
    function automatic logic [PIX_W-1:0] next_pixel(input int style);
        case (style)
            1: return PIX_W'($urandom_range(0, 3));
            2: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            3: return PIX_W'($urandom_range(120, 136));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Flat areas give code 0 and local minima give code 255, so those two
    // bins usually hold real counts; the rest of the reads go anywhere.
    function automatic logic [BIN_W-1:0] pick_bin();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BIN_W'($urandom);
        endcase
    endfunction

    // Presents one input beat and returns right after the edge that takes it.
    // Valid drops only when a gap is drawn, so back-to-back beats keep it high.
    task automatic send_beat(input logic [1:0] cmd, input logic [PIX_W-1:0] px,
                             input logic [BIN_W-1:0] bin);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_cmd   <= cmd;
        src_pixel <= px;
        src_bin   <= bin;
        src_valid <= 1'b1;
        @(posedge clk);
        while (!(src_valid && dut_ready)) @(posedge clk);
        beats_sent++;
    endtask

    // Stops the input side, lets every expected result arrive and then gives
    // the pipeline time to finish pixel beats that return nothing.
    task automatic settle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input int raw_w, input int raw_h);
        settle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(raw_w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(raw_h));
    endtask

    // Result side: a fresh stall is drawn for every beat. Ready is lowered
    // only when the stall is nonzero, so it never falls and rises in one step.
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge clk);
            stall = next_gap();
            if (stall > 0) begin
                sink_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            sink_ready <= 1'b1;
            @(posedge clk);
            while (!(res_valid && sink_ready)) @(posedge clk);
        end
    end

    // Watchdog: a run that stops moving beats on both channels is a hang.
    always @(posedge clk) begin
        if ((src_valid && dut_ready) || (res_valid && sink_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
                     STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int w;
        int h;
        int raw_w;
        int raw_h;
        int style;
        int shrink_at;
        int roll;
        int useful;

        useful = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Both registers get values below the legal range and
        // must clamp to the smallest 3x3 frame, which yields a single code.
        configure(0, 2);
        for (int k = 0; k < 9; k++) send_beat(CMD_PIXEL, PROBE_FRAME[k], BIN_W'($urandom));
        // The frame is complete: a further pixel and an unknown command are dropped.
        send_beat(CMD_PIXEL, 8'd77, 8'h5A);
        send_beat(CMD_UNUSED, 8'hFF, 8'hFF);
        send_beat(CMD_READ, 8'hA5, PROBE_CODE);
        send_beat(CMD_READ, 8'h00, 8'h00);
        send_beat(CMD_READ, 8'hFF, 8'hFF);
        // Start clears the histogram, so the probe bin must read back empty.
        send_beat(CMD_START, 8'h00, 8'h00);
        send_beat(CMD_READ, 8'h5A, PROBE_CODE);

        // Random frames. Most are small; a few are wider. Every frame begins
        // from a fresh configuration and a start, so the line stores are
        // always filled by the current frame before the window reads them.
        while (useful < RANDOM_BEATS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
            h = $urandom_range(3, 6);
            raw_w = (w == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : w;
            raw_h = (h == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : h;
            configure(raw_w, raw_h);
            no_idle   = ($urandom_range(0, 3) == 0);
            style     = $urandom_range(0, 3);
            shrink_at = ($urandom_range(0, 3) == 0) ? $urandom_range(2 * w, w * h - 1) : -1;
            send_beat(CMD_START, PIX_W'($urandom), BIN_W'($urandom));
            useful++;

            for (int p = 0; p < w * h; p++) begin
                // Mid-frame the geometry may only shrink: narrowing to at most
                // the current column ends the row at this pixel, and a height
                // at or below the current row closes the frame early.
                if (p == shrink_at) begin
                    settle();
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(REG_IMAGE_WIDTH,
                                  DIM_W'($urandom_range(3, (p % w) + 1 > 3 ? (p % w) + 1 : 3)));
                    end else begin
                        write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, p / w + 1)));
                    end
                end
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    send_beat(CMD_READ, PIX_W'($urandom), pick_bin());
                    useful++;
                end else if (roll < 7) begin
                    send_beat(CMD_UNUSED, PIX_W'($urandom), BIN_W'($urandom));
                end else if (roll == 7) begin
                    // An early start abandons the frame and clears the histogram.
                    send_beat(CMD_START, PIX_W'($urandom), BIN_W'($urandom));
                    useful++;
                end
                send_beat(CMD_PIXEL, next_pixel(style), BIN_W'($urandom));
                useful++;
            end

            // Pixels past the frame end, then a few bin reads.
            repeat ($urandom_range(0, 3))
                send_beat(CMD_PIXEL, next_pixel(style), BIN_W'($urandom));
            repeat ($urandom_range(1, 4)) begin
                send_beat(CMD_READ, PIX_W'($urandom), pick_bin());
                useful++;
            end
        end

        // Register values above the range must clamp to the largest frame. A
        // first row longer than any random frame shows that the width was not
        // cut short; the geometry is then lowered mid-row, which ends that row
        // at the current pixel and keeps the frame small.
        configure(2047, 1025);
        no_idle = 1'b1;
        send_beat(CMD_START, PIX_W'($urandom), BIN_W'($urandom));
        for (int p = 0; p < CLAMP_COLS; p++)
            send_beat(CMD_PIXEL, next_pixel(p % 4), BIN_W'($urandom));
        settle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(CLAMP_COLS + 1));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
        for (int p = 0; p < 2 * CLAMP_COLS + 3; p++)
            send_beat(CMD_PIXEL, next_pixel(p % 4), BIN_W'($urandom));
        send_beat(CMD_READ, PIX_W'($urandom), 8'h00);
        send_beat(CMD_READ, PIX_W'($urandom), 8'hFF);
        repeat (4) send_beat(CMD_READ, PIX_W'($urandom), pick_bin());

        no_idle = 1'b0;
        settle();

        $display("Sent %0d beats (%0d in random frames up to 40 wide), a 3x3 probe and",
                 beats_sent, useful);
        $display("a frame from oversized registers; checked %0d codes, %0d reads, %0d frame ends.",
                 codes_checked, reads_checked, frames_closed);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d result beats were wrong.", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lbp_pkg.sv
rtl/lbp_front.sv
rtl/lbp_queue.sv
rtl/lbp_back.sv
rtl/lbp_code_histogram.sv
tb/lbp_code_histogram_checker.sv
tb/lbp_code_histogram_tb.sv
